/* sv/pms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

    localparam int MAX_NOTES    = 64;
    localparam int NOTE_IDX_W   = $clog2(MAX_NOTES);
    localparam int NOTE_CNT_W   = $clog2(MAX_NOTES + 1);
    localparam int RELOAD_W     = 16;
    localparam int DURATION_W   = 16;
    localparam int CMP_W        = 15;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int BEEP_AGE_W   = 32;

    localparam logic [RELOAD_W-1:0] RESET_RELOAD     = 16'd369;
    localparam logic [15:0]         RESET_BEEP_PERIOD = 16'd500;

    // floor(2*y/5) == (y * 419432) >> 20 for y < 2^17
    localparam logic [18:0] DUTY_MUL   = 19'd419432;
    localparam int          DUTY_SHIFT = 20;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEEP_PERIOD = 2'd0,
        CFG_BEEP_ENABLE = 2'd1,
        CFG_REST_MARKER = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [RELOAD_W-1:0]   reload;
        logic [DURATION_W-1:0] duration;
    } note_t;

endpackage

`default_nettype wire

/* sv/pms_note_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

// Note table: one write port, one registered read port, write-first on collision.
module pms_note_mem (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [pms_pkg::NOTE_IDX_W-1:0] wr_addr,
    input  wire pms_pkg::note_t                 wr_data,
    input  wire logic [pms_pkg::NOTE_IDX_W-1:0] rd_addr,
    output pms_pkg::note_t                      rd_data
);
    import pms_pkg::*;

    note_t mem [MAX_NOTES];
    note_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/pwm_melody_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// The result of a transaction accepted at edge N is on the output ports, with done
//   high, during the cycle after edge N.
// Throughput: one transaction per cycle; busy is tied low (single stage).
// Reset (rst_n low, async): melody stopped, output silent, reload 369, beep off,
//   beep period 500, rest marker 0. The note table is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module pwm_melody_sequencer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // command channel
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       opcode,
    input  wire logic [pms_pkg::NOTE_IDX_W-1:0]   entry_index,
    input  wire logic [pms_pkg::RELOAD_W-1:0]     entry_reload,
    input  wire logic [pms_pkg::DURATION_W-1:0]   entry_duration_ms,
    input  wire logic [pms_pkg::NOTE_CNT_W-1:0]   melody_length,
    input  wire logic                             only_if_idle,

    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [pms_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [pms_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    // result channel
    output logic                                  done,
    output logic                                  sound_on,
    output logic [pms_pkg::RELOAD_W-1:0]          reload_value,
    output logic [pms_pkg::CMP_W-1:0]             compare_value,
    output logic                                  melody_active,
    output logic [pms_pkg::NOTE_IDX_W-1:0]        current_note,
    output logic                                  melody_finished
);
    import pms_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]         beep_period_reg;
    logic                beep_enable_reg;
    logic [RELOAD_W-1:0] rest_marker_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_period_reg <= RESET_BEEP_PERIOD;
            beep_enable_reg <= 1'b0;
            rest_marker_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_BEEP_PERIOD: beep_period_reg <= cfg_wdata;
                CFG_BEEP_ENABLE: beep_enable_reg <= cfg_wdata[0];
                CFG_REST_MARKER: rest_marker_reg <= cfg_wdata;
                default:         ;   // index beyond the register list: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Player state
    // Time is kept as ages instead of absolute stamps:
    //   note_age = now - note_start, beep_age = now - last_toggle (mod 2^32).
    // note_age stays below the note length while playing, so 16 bits do.
    // ------------------------------------------------------------------
    logic [DURATION_W-1:0] note_age_reg,    note_age_next;
    logic [DURATION_W-1:0] note_len_reg,    note_len_next;
    logic [BEEP_AGE_W-1:0] beep_age_reg,    beep_age_next;
    logic [NOTE_CNT_W-1:0] pointer_reg,     pointer_next;
    logic [NOTE_CNT_W-1:0] notes_reg,       notes_next;
    logic                  playing_reg,     playing_next;
    logic                  output_on_reg,   output_on_next;
    logic [RELOAD_W-1:0]   reload_reg,      reload_next;
    logic [CMP_W-1:0]      compare_reg,     compare_next;
    logic                  finished_reg,    finished_next;
    logic                  done_reg;

    // Entry 0 is mirrored in flops so a start never waits on the memory.
    note_t first_note_reg;

    // The memory port always prefetches the entry after the current pointer,
    // so a tick that ends the note finds the next one already registered.
    note_t                 next_note;
    logic                  mem_we;
    note_t                 mem_wdata;
    logic [NOTE_IDX_W-1:0] mem_raddr;

    pms_note_mem u_note_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (entry_index),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (next_note)
    );

    logic    accept;
    opcode_t op;
    logic    write_ok;

    assign accept    = start && !busy;
    assign op        = opcode_t'(opcode);
    assign write_ok  = ({1'b0, entry_index} < NOTE_CNT_W'(MAX_NOTES));
    assign mem_we    = accept && (op == OP_WRITE) && write_ok;
    assign mem_wdata = '{reload: entry_reload, duration: entry_duration_ms};
    assign mem_raddr = pointer_next[NOTE_IDX_W-1:0] + NOTE_IDX_W'(1);

    // ------------------------------------------------------------------
    // Next-state logic for one transaction
    // ------------------------------------------------------------------
    logic [DURATION_W:0]   note_age_inc;
    logic [BEEP_AGE_W-1:0] beep_age_inc;
    logic [NOTE_CNT_W-1:0] pointer_inc;
    logic                  note_done;
    note_t                 load_note;
    logic                  load_en;
    logic                  load_rest;

    always_comb
    begin
        note_age_next  = note_age_reg;
        note_len_next  = note_len_reg;
        beep_age_next  = beep_age_reg;
        pointer_next   = pointer_reg;
        notes_next     = notes_reg;
        playing_next   = playing_reg;
        output_on_next = output_on_reg;
        reload_next    = reload_reg;
        finished_next  = 1'b0;

        note_age_inc = {1'b0, note_age_reg} + (DURATION_W+1)'(1);
        beep_age_inc = beep_age_reg + BEEP_AGE_W'(1);
        pointer_inc  = pointer_reg + NOTE_CNT_W'(1);
        note_done    = playing_reg && (note_age_inc >= {1'b0, note_len_reg});
        load_note    = first_note_reg;
        load_en      = 1'b0;

        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    note_age_next = note_age_inc[DURATION_W-1:0];
                    if (note_done)
                    begin
                        pointer_next = pointer_inc;
                        if (pointer_inc < notes_reg)
                        begin
                            load_note = next_note;
                            load_en   = 1'b1;
                        end
                        else
                        begin
                            playing_next   = 1'b0;
                            output_on_next = 1'b0;
                            finished_next  = 1'b1;
                        end
                    end
                end
                OP_START:
                begin
                    if ((melody_length != '0) && !(only_if_idle && playing_reg))
                    begin
                        notes_next   = (melody_length > NOTE_CNT_W'(MAX_NOTES)) ?
                                       NOTE_CNT_W'(MAX_NOTES) : melody_length;
                        pointer_next = '0;
                        load_note    = first_note_reg;
                        load_en      = 1'b1;
                    end
                end
                default: ;   // note writes go to the memory; OP_NONE changes nothing
            endcase
        end

        // start of a note
        load_rest = (load_note.reload == '0) || (load_note.reload == rest_marker_reg);
        if (load_en)
        begin
            if (load_rest)
            begin
                output_on_next = 1'b0;
            end
            else
            begin
                reload_next    = load_note.reload;
                output_on_next = 1'b1;
            end
            note_age_next = '0;
            note_len_next = load_note.duration;
            playing_next  = 1'b1;
        end

        // beep mode runs after the melody update within a tick
        if (accept && (op == OP_TICK))
        begin
            if (!playing_next && beep_enable_reg &&
                (beep_age_inc >= BEEP_AGE_W'(beep_period_reg)))
            begin
                output_on_next = !output_on_next;
                beep_age_next  = '0;
            end
            else
            begin
                beep_age_next  = beep_age_inc;
            end
        end
    end

    // Compare value: 40 percent of (reload + 1), by reciprocal multiply.
    logic [RELOAD_W:0] period_len;
    logic [35:0]       duty_prod;

    assign period_len   = {1'b0, reload_next} + (RELOAD_W+1)'(1);
    assign duty_prod    = 36'(period_len) * 36'(DUTY_MUL);
    assign compare_next = output_on_next ? duty_prod[DUTY_SHIFT+CMP_W-1:DUTY_SHIFT] : '0;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_age_reg  <= '0;
            note_len_reg  <= '0;
            beep_age_reg  <= '0;
            pointer_reg   <= '0;
            notes_reg     <= '0;
            playing_reg   <= 1'b0;
            output_on_reg <= 1'b0;
            reload_reg    <= RESET_RELOAD;
            compare_reg   <= '0;
            finished_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            note_age_reg  <= note_age_next;
            note_len_reg  <= note_len_next;
            beep_age_reg  <= beep_age_next;
            pointer_reg   <= pointer_next;
            notes_reg     <= notes_next;
            playing_reg   <= playing_next;
            output_on_reg <= output_on_next;
            reload_reg    <= reload_next;
            compare_reg   <= compare_next;
            finished_reg  <= finished_next;
            done_reg      <= accept;
        end
    end

    // entry 0 mirror, undefined until written
    always_ff @(posedge clk)
    begin
        if (mem_we && (entry_index == '0))
        begin
            first_note_reg <= mem_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy            = 1'b0;
    assign done            = done_reg;
    assign sound_on        = output_on_reg;
    assign reload_value    = reload_reg;
    assign compare_value   = compare_reg;
    assign melody_active   = playing_reg;
    assign current_note    = playing_reg ? pointer_reg[NOTE_IDX_W-1:0] : '0;
    assign melody_finished = finished_reg;

endmodule

`default_nettype wire

/* bench/pwm_melody_sequencer_top_tb.sv */
`timescale 1ns / 1ps

// Melody sequencer bench: a directed table of commands followed by random
// phases under several register settings. Every transaction is run through a
// local player model; each done strobe is checked against the oldest entry.
module pwm_melody_sequencer_top_tb;

    import pms_pkg::*;

    localparam int ITEMS_PER_PHASE = 122;
    localparam int NUM_PHASES      = 6;
    localparam int WATCHDOG_LIMIT  = 1000;
    // spare cycles after the last result, before touching registers
    localparam int DRAIN_CYCLES    = 3;
    localparam int DUTY_PCT        = 40;
    localparam int PCT_SCALE       = 100;

    typedef struct packed {
        opcode_t               op;
        logic [NOTE_IDX_W-1:0] idx;
        logic [RELOAD_W-1:0]   reload;
        logic [DURATION_W-1:0] dur;
        logic [NOTE_CNT_W-1:0] len;
        logic                  idle;
    } cmd_t;

    typedef struct packed {
        logic                  sound;
        logic [RELOAD_W-1:0]   reload;
        logic [CMP_W-1:0]      cmp;
        logic                  active;
        logic [NOTE_IDX_W-1:0] note;
        logic                  finished;
    } player_out_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        typed;
        player_out_t want;
    } stim_row_t;

    // ------------------------------------------------------------------
    // DUT pins. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                  clk               = 1'b0;
    logic                  rst_n             = 1'b0;
    logic                  start             = 1'b0;
    logic                  busy;
    logic [1:0]            opcode            = '0;
    logic [NOTE_IDX_W-1:0] entry_index       = '0;
    logic [RELOAD_W-1:0]   entry_reload      = '0;
    logic [DURATION_W-1:0] entry_duration_ms = '0;
    logic [NOTE_CNT_W-1:0] melody_length     = '0;
    logic                  only_if_idle      = 1'b0;
    logic                  cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr          = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata         = '0;
    logic                  done;
    logic                  sound_on;
    logic [RELOAD_W-1:0]   reload_value;
    logic [CMP_W-1:0]      compare_value;
    logic                  melody_active;
    logic [NOTE_IDX_W-1:0] current_note;
    logic                  melody_finished;

    pwm_melody_sequencer_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .opcode            (opcode),
        .entry_index       (entry_index),
        .entry_reload      (entry_reload),
        .entry_duration_ms (entry_duration_ms),
        .melody_length     (melody_length),
        .only_if_idle      (only_if_idle),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .done              (done),
        .sound_on          (sound_on),
        .reload_value      (reload_value),
        .compare_value     (compare_value),
        .melody_active     (melody_active),
        .current_note      (current_note),
        .melody_finished   (melody_finished)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Player model state, at the block's widths, starting from reset.
    // ------------------------------------------------------------------
    logic [31:0]           now_ms_q      = '0;
    logic [31:0]           toggle_ms_q   = '0;
    logic [31:0]           note_t0_q     = '0;
    logic [DURATION_W-1:0] note_len_q    = '0;
    logic [NOTE_CNT_W-1:0] note_ptr_q    = '0;
    logic [NOTE_CNT_W-1:0] melody_len_q  = '0;
    logic                  playing_q     = 1'b0;
    logic                  out_on_q      = 1'b0;
    logic [RELOAD_W-1:0]   cur_reload_q  = RESET_RELOAD;
    logic [RELOAD_W-1:0]   tbl_reload [MAX_NOTES];
    logic [DURATION_W-1:0] tbl_dur    [MAX_NOTES];
    // the table powers up undefined: starts only ever reach written entries
    logic [MAX_NOTES-1:0]  entry_written = '0;

    logic [15:0]           beep_period_q = RESET_BEEP_PERIOD;
    logic                  beep_en_q     = 1'b0;
    logic [RELOAD_W-1:0]   rest_marker_q = '0;

    player_out_t           pending_outputs [$];
    stim_row_t             dir_rows [$];

    int errors       = 0;
    int useful_items = 0;
    int burst_left   = 0;
    int stall_cycles = 0;
    int n_ticks      = 0;
    int n_writes     = 0;
    int n_starts     = 0;
    int n_ignored    = 0;
    int n_finished   = 0;
    int n_rests      = 0;
    int n_toggles    = 0;
    int n_settings   = 0;
    int n_checked    = 0;

    // Enter note i of the table: a rest keeps the old reload value.
    task automatic load_note(input logic [NOTE_CNT_W-1:0] i);
        logic [RELOAD_W-1:0] rl;
        rl = tbl_reload[i[NOTE_IDX_W-1:0]];
        if (rl == '0 || rl == rest_marker_q)
        begin
            out_on_q = 1'b0;
            n_rests++;
        end
        else
        begin
            cur_reload_q = rl;
            out_on_q     = 1'b1;
        end
        note_t0_q  = now_ms_q;
        note_len_q = tbl_dur[i[NOTE_IDX_W-1:0]];
        playing_q  = 1'b1;
    endtask

    // One accepted command through the player; returns the state it reports.
    task automatic player_step(input cmd_t c, output player_out_t r);
        logic [31:0] elapsed;
        logic        fin;
        int unsigned cmp_full;
        fin = 1'b0;
        case (c.op)
            OP_TICK:
            begin
                n_ticks++;
                useful_items++;
                now_ms_q = now_ms_q + 32'd1;
                elapsed  = now_ms_q - note_t0_q;
                if (playing_q && elapsed >= {16'd0, note_len_q})
                begin
                    note_ptr_q = note_ptr_q + NOTE_CNT_W'(1);
                    if (note_ptr_q < melody_len_q)
                        load_note(note_ptr_q);
                    else
                    begin
                        playing_q = 1'b0;
                        out_on_q  = 1'b0;
                        fin       = 1'b1;
                        n_finished++;
                    end
                end
                // beep runs after the melody update, on the same tick
                elapsed = now_ms_q - toggle_ms_q;
                if (!playing_q && beep_en_q && elapsed >= {16'd0, beep_period_q})
                begin
                    out_on_q    = ~out_on_q;
                    toggle_ms_q = now_ms_q;
                    n_toggles++;
                end
            end
            OP_WRITE:
            begin
                // the 6-bit index cannot point past the table
                n_writes++;
                useful_items++;
                tbl_reload[c.idx]    = c.reload;
                tbl_dur[c.idx]       = c.dur;
                entry_written[c.idx] = 1'b1;
            end
            OP_START:
            begin
                if (c.len != '0 && !(c.idle && playing_q))
                begin
                    n_starts++;
                    useful_items++;
                    melody_len_q = (c.len > NOTE_CNT_W'(MAX_NOTES)) ?
                                   NOTE_CNT_W'(MAX_NOTES) : c.len;
                    note_ptr_q   = '0;
                    load_note('0);
                end
                else
                    n_ignored++;
            end
            default:
                n_ignored++;
        endcase
        cmp_full = 0;
        if (out_on_q)
            cmp_full = (32'(cur_reload_q) + 1) * DUTY_PCT / PCT_SCALE;
        r.sound    = out_on_q;
        r.reload   = cur_reload_q;
        r.cmp      = cmp_full[CMP_W-1:0];
        r.active   = playing_q;
        r.note     = playing_q ? note_ptr_q[NOTE_IDX_W-1:0] : '0;
        r.finished = fin;
    endtask

    // Random command. Writes mostly extend the written prefix of the table
    // so that starts can pick lengths up to it; starts never reach an
    // unwritten entry. Unused fields carry random bits.
    function automatic cmd_t next_random_cmd();
        cmd_t c;
        int   roll;
        int   ready;
        c.idx    = NOTE_IDX_W'($urandom);
        c.reload = RELOAD_W'($urandom);
        c.dur    = DURATION_W'($urandom);
        c.len    = NOTE_CNT_W'($urandom);
        c.idle   = 1'($urandom);
        ready = 0;
        while (ready < MAX_NOTES && entry_written[ready])
            ready++;
        roll = $urandom_range(0, 99);
        if (roll < 52)
            c.op = OP_TICK;
        else if (roll < 74)
        begin
            c.op = OP_WRITE;
            if (ready < MAX_NOTES && $urandom_range(0, 3) != 0)
                c.idx = NOTE_IDX_W'(ready);
            roll = $urandom_range(0, 99);
            if (roll < 15)
                c.reload = '0;
            else if (roll < 30)
                c.reload = rest_marker_q;
            else if (roll < 40)
                c.reload = RELOAD_W'($urandom_range(1, 3));
            roll = $urandom_range(0, 99);
            if (roll < 65)
                c.dur = DURATION_W'($urandom_range(0, 4));
            else if (roll < 90)
                c.dur = DURATION_W'($urandom_range(5, 20));
        end
        else if (roll < 94)
        begin
            c.op = OP_START;
            roll = $urandom_range(0, 99);
            if (ready == 0 || roll < 4)
                c.len = '0;
            else if (ready == MAX_NOTES && roll < 24)
                c.len = NOTE_CNT_W'($urandom_range(MAX_NOTES, 127));
            else if (roll < 60)
                c.len = NOTE_CNT_W'($urandom_range(1, (ready < 4) ? ready : 4));
            else
                c.len = NOTE_CNT_W'($urandom_range(1, ready));
        end
        else
            c.op = OP_NONE;
        return c;
    endfunction

    task automatic add_row(input opcode_t op, input int idx, input int rel, input int dur,
                           input int len, input int idle, input int typed,
                           input int snd, input int rv, input int cv, input int act,
                           input int note, input int fin);
        stim_row_t r;
        r.cmd.op        = op;
        r.cmd.idx       = NOTE_IDX_W'(idx);
        r.cmd.reload    = RELOAD_W'(rel);
        r.cmd.dur       = DURATION_W'(dur);
        r.cmd.len       = NOTE_CNT_W'(len);
        r.cmd.idle      = 1'(idle);
        r.typed         = 1'(typed);
        r.want.sound    = 1'(snd);
        r.want.reload   = RELOAD_W'(rv);
        r.want.cmp      = CMP_W'(cv);
        r.want.active   = 1'(act);
        r.want.note     = NOTE_IDX_W'(note);
        r.want.finished = 1'(fin);
        dir_rows.push_back(r);
    endtask

    // Sender: bursts of random length separated by random gaps. The command
    // is held until the edge at which start is high and busy is low; that
    // transaction is run through the model there. A typed row queues its
    // typed value instead of the model's.
    task automatic send_cmd(input cmd_t c, input logic typed, input player_out_t want);
        player_out_t got;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        start             <= 1'b1;
        opcode            <= c.op;
        entry_index       <= c.idx;
        entry_reload      <= c.reload;
        entry_duration_ms <= c.dur;
        melody_length     <= c.len;
        only_if_idle      <= c.idle;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        player_step(c, got);
        pending_outputs.push_back(typed ? want : got);
    endtask

    // Lower start and let every queued result come back before going on.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t a, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge clk);
        case (a)
            CFG_BEEP_PERIOD: beep_period_q = v;
            CFG_BEEP_ENABLE: beep_en_q     = v[0];
            CFG_REST_MARKER: rest_marker_q = v;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker. Outputs are sampled at the edge that ends the strobe
    // cycle, so the values seen are the ones held during that cycle.
    // ------------------------------------------------------------------
    player_out_t head;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("done strobe with no transaction outstanding");
                errors++;
            end
            else
            begin
                head = pending_outputs.pop_front();
                n_checked++;
                check_field("sound_on",        32'(head.sound),    32'(sound_on));
                check_field("reload_value",    32'(head.reload),   32'(reload_value));
                check_field("compare_value",   32'(head.cmp),      32'(compare_value));
                check_field("melody_active",   32'(head.active),   32'(melody_active));
                check_field("current_note",    32'(head.note),     32'(current_note));
                check_field("melody_finished", 32'(head.finished), 32'(melody_finished));
            end
        end
    end

    // Watchdog: cycles in which neither a command nor a result moved.
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [15:0] per;
        logic        en;
        logic [15:0] mk;
        int          target;

        // Directed table, reset settings (beep off, period 500, marker 0).
        // Typed rows: the state right after reset, extremes of the reload
        // value, and commands that must change nothing.
        //       op        idx rel    dur    len idle typ snd rv     cv     act nt fin
        add_row(OP_TICK,   0,  0,     0,     0,  0,   1,  0,  369,   0,     0,  0, 0);
        add_row(OP_NONE,   63, 65535, 65535, 127, 1,  1,  0,  369,   0,     0,  0, 0);
        // zero-length start is dropped
        add_row(OP_START,  0,  0,     0,     0,  0,   1,  0,  369,   0,     0,  0, 0);
        // note table: full-scale tone with zero duration, a rest, a tone whose
        // compare rounds to zero, a mid tone, and the last entry at max time
        add_row(OP_WRITE,  0,  65535, 0,     0,  0,   1,  0,  369,   0,     0,  0, 0);
        add_row(OP_WRITE,  1,  0,     1,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_WRITE,  2,  1,     2,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_WRITE,  3,  12345, 3,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_WRITE,  63, 40000, 65535, 0,  0,   0,  0,  0,     0,     0,  0, 0);
        // idle-only start while nothing plays: goes ahead at full scale
        add_row(OP_START,  0,  0,     0,     4,  1,   1,  1,  65535, 26214, 1,  0, 0);
        add_row(OP_TICK,   0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_TICK,   0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        // idle-only start during a melody is dropped
        add_row(OP_START,  0,  0,     0,     4,  1,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_TICK,   0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_TICK,   0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        // plain start during a melody restarts it from entry 0
        add_row(OP_START,  0,  0,     0,     2,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_TICK,   0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_TICK,   0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_TICK,   0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        // one-note melody of zero duration ends on the next tick
        add_row(OP_START,  0,  0,     0,     1,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_TICK,   0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        // entry 0 becomes a rest: melody active but silent
        add_row(OP_WRITE,  0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_START,  0,  0,     0,     1,  1,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_TICK,   0,  0,     0,     0,  0,   0,  0,  0,     0,     0,  0, 0);
        add_row(OP_NONE,   5,  77,    9,     3,  0,   0,  0,  0,     0,     0,  0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

        // Random phases, each under its own register setting; registers
        // change only once the block has gone quiet.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                0:       begin per = 16'd0;     en = 1'b1; mk = 16'd12345;  end
                1:       begin per = 16'd3;     en = 1'b1; mk = 16'hFFFF;   end
                2:       begin per = 16'hFFFF;  en = 1'b1; mk = 16'd0;      end
                3:       begin per = 16'd1;     en = 1'b0; mk = 16'd7;      end
                4:       begin per = 16'd17;    en = 1'b1; mk = 16'($urandom); end
                default: begin per = 16'd2;     en = 1'b1; mk = 16'd2;      end
            endcase
            write_reg(CFG_BEEP_PERIOD, per);
            write_reg(CFG_BEEP_ENABLE, {15'd0, en});
            write_reg(CFG_REST_MARKER, mk);
            cfg_we <= 1'b0;
            n_settings++;
            target = useful_items + ITEMS_PER_PHASE;
            while (useful_items < target)
                send_cmd(next_random_cmd(), 1'b0, '0);
        end

        drain();

        $display("summary: %0d ticks, %0d writes, %0d starts, %0d ignored, %0d checked",
                 n_ticks, n_writes, n_starts, n_ignored, n_checked);
        $display("summary: %0d melodies ended, %0d rests, %0d beep toggles, %0d settings",
                 n_finished, n_rests, n_toggles, n_settings);
        if (errors == 0 && pending_outputs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
